// ===== hw/rtl/bfp_pkg.sv =====
// Shared types, constants and CRC function of the binary frame parser.
`timescale 1ns / 1ps

package bfp_pkg;

    localparam int HdrLen     = 24;
    localparam int TrailerLen = 4;
    localparam int QueueDepth = 4;

    localparam logic [31:0] CrcPoly = 32'hEDB88320;

    localparam logic [7:0] FirstSyncReset  = 8'hAA;
    localparam logic [7:0] SecondSyncReset = 8'h44;
    localparam logic [7:0] ThirdSyncReset  = 8'hB5;

    // Configuration register indexes
    localparam logic [1:0] RegFirstSync  = 2'd0;
    localparam logic [1:0] RegSecondSync = 2'd1;
    localparam logic [1:0] RegThirdSync  = 2'd2;

    // Result kinds
    localparam logic KindPayload  = 1'b0;
    localparam logic KindFrameEnd = 1'b1;

    // Framer phases, one-hot
    typedef enum logic [5:0] {
        PH_SYNC1   = 6'b000001,
        PH_SYNC2   = 6'b000010,
        PH_SYNC3   = 6'b000100,
        PH_HEADER  = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_TRAILER = 6'b100000
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [8:0]  byte_offset;
        logic [15:0] message_id;
        logic [9:0]  payload_length;
        logic [15:0] week_number;
        logic [31:0] ms_of_week;
        logic [7:0]  time_status;
        logic [31:0] received_crc;
        logic        crc_ok;
    } result_t;

    // Reflected CRC-32 update by one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CrcPoly : 32'h0);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/bfp_framer.sv =====
// Front end: sync hunt, header capture, length choice, CRC and result build.
`timescale 1ns / 1ps

module bfp_framer #(
    parameter int MAX_PAYLOAD = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              byte_valid,
    input  logic [7:0]        rx_byte,
    output logic              push,
    output bfp_pkg::result_t  result
);

    localparam int LW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);
    localparam logic [4:0]  HdrLast = 5'(bfp_pkg::HdrLen - 1);
    localparam logic [1:0]  TrlLast = 2'(bfp_pkg::TrailerLen - 1);

    logic [7:0] first_sync_reg, second_sync_reg, third_sync_reg;

    bfp_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  hdr_idx_reg, hdr_idx_next;
    logic [LW-1:0] pay_idx_reg, pay_idx_next;
    logic [LW-1:0] len_reg, len_next;
    logic [1:0]  trl_idx_reg, trl_idx_next;
    logic [31:0] crc_reg, crc_next;
    logic [23:0] trl_reg, trl_next;

    // Header bytes that are used later
    logic [7:0]  hs0_reg, hs1_reg, hs2_reg;
    logic [7:0]  hs0_next, hs1_next, hs2_next;
    logic [15:0] msg_id_reg, msg_id_next;
    logic [15:0] len_raw_reg, len_raw_next;
    logic [7:0]  tstat_reg, tstat_next;
    logic [15:0] week_reg, week_next;
    logic [31:0] ms_reg, ms_next;

    logic [31:0] crc_seed, crc_upd;
    logic [15:0] len_le, len_sw, len_a, len_sub;
    logic        fit_le, fit_sw, fit_a, fit_sub, sync_ok;
    logic [15:0] len_pick;
    logic        len_ok;
    logic [31:0] rcv_crc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sync_reg  <= bfp_pkg::FirstSyncReset;
            second_sync_reg <= bfp_pkg::SecondSyncReset;
            third_sync_reg  <= bfp_pkg::ThirdSyncReset;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bfp_pkg::RegFirstSync:  first_sync_reg  <= cfg_data;
                bfp_pkg::RegSecondSync: second_sync_reg <= cfg_data;
                bfp_pkg::RegThirdSync:  third_sync_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign crc_seed = (phase_reg == bfp_pkg::PH_SYNC1) ? 32'h0 : crc_reg;
    assign crc_upd  = bfp_pkg::crc32_byte(crc_seed, rx_byte);

    // Length choice with fallbacks
    assign len_le  = len_raw_reg;
    assign len_sw  = {len_raw_reg[7:0], len_raw_reg[15:8]};
    assign fit_le  = (len_le <= MaxLen);
    assign fit_sw  = (len_sw <= MaxLen);
    assign len_a   = (!fit_le && fit_sw) ? len_sw : len_le;
    assign fit_a   = (len_a <= MaxLen);
    assign len_sub = len_a - 16'd4;
    assign fit_sub = (len_a >= 16'd4) && (len_sub <= MaxLen);
    assign len_pick = fit_a ? len_a : len_sub;
    assign sync_ok = (hs0_reg == first_sync_reg) && (hs1_reg == second_sync_reg)
                  && (hs2_reg == third_sync_reg);
    assign len_ok  = sync_ok && (fit_a || fit_sub);

    assign rcv_crc = {rx_byte, trl_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        pay_idx_next = pay_idx_reg;
        len_next     = len_reg;
        trl_idx_next = trl_idx_reg;
        crc_next     = crc_reg;
        trl_next     = trl_reg;
        hs0_next     = hs0_reg;
        hs1_next     = hs1_reg;
        hs2_next     = hs2_reg;
        msg_id_next  = msg_id_reg;
        len_raw_next = len_raw_reg;
        tstat_next   = tstat_reg;
        week_next    = week_reg;
        ms_next      = ms_reg;
        push         = 1'b0;
        result       = '0;

        if (byte_valid)
        begin
            unique case (phase_reg)
                bfp_pkg::PH_SYNC2:
                begin
                    if (rx_byte == second_sync_reg)
                    begin
                        hs1_next   = rx_byte;
                        crc_next   = crc_upd;
                        phase_next = bfp_pkg::PH_SYNC3;
                    end
                    else
                    begin
                        phase_next = bfp_pkg::PH_SYNC1;
                    end
                end
                bfp_pkg::PH_SYNC3:
                begin
                    if (rx_byte == third_sync_reg)
                    begin
                        hs2_next     = rx_byte;
                        crc_next     = crc_upd;
                        hdr_idx_next = 5'd3;
                        phase_next   = bfp_pkg::PH_HEADER;
                    end
                    else
                    begin
                        phase_next = bfp_pkg::PH_SYNC1;
                    end
                end
                bfp_pkg::PH_HEADER:
                begin
                    crc_next     = crc_upd;
                    hdr_idx_next = hdr_idx_reg + 5'd1;
                    unique case (hdr_idx_reg)
                        5'd4:  msg_id_next[7:0]   = rx_byte;
                        5'd5:  msg_id_next[15:8]  = rx_byte;
                        5'd6:  len_raw_next[7:0]  = rx_byte;
                        5'd7:  len_raw_next[15:8] = rx_byte;
                        5'd9:  tstat_next         = rx_byte;
                        5'd10: week_next[7:0]     = rx_byte;
                        5'd11: week_next[15:8]    = rx_byte;
                        5'd12: ms_next[7:0]       = rx_byte;
                        5'd13: ms_next[15:8]      = rx_byte;
                        5'd14: ms_next[23:16]     = rx_byte;
                        5'd15: ms_next[31:24]     = rx_byte;
                        default: ;
                    endcase
                    if (hdr_idx_reg == HdrLast)
                    begin
                        if (!len_ok)
                        begin
                            phase_next = bfp_pkg::PH_SYNC1;
                        end
                        else
                        begin
                            len_next     = LW'(len_pick);
                            pay_idx_next = '0;
                            trl_idx_next = '0;
                            phase_next   = (len_pick == 16'd0) ? bfp_pkg::PH_TRAILER
                                                               : bfp_pkg::PH_PAYLOAD;
                        end
                    end
                end
                bfp_pkg::PH_PAYLOAD:
                begin
                    push               = 1'b1;
                    result.kind        = bfp_pkg::KindPayload;
                    result.data_byte   = rx_byte;
                    result.byte_offset = 9'(pay_idx_reg);
                    crc_next           = crc_upd;
                    pay_idx_next       = pay_idx_reg + LW'(1);
                    if (pay_idx_next == len_reg)
                    begin
                        trl_idx_next = '0;
                        phase_next   = bfp_pkg::PH_TRAILER;
                    end
                end
                bfp_pkg::PH_TRAILER:
                begin
                    trl_idx_next = trl_idx_reg + 2'd1;
                    unique case (trl_idx_reg)
                        2'd0:    trl_next[7:0]   = rx_byte;
                        2'd1:    trl_next[15:8]  = rx_byte;
                        2'd2:    trl_next[23:16] = rx_byte;
                        default: ;
                    endcase
                    if (trl_idx_reg == TrlLast)
                    begin
                        push                  = 1'b1;
                        result.kind           = bfp_pkg::KindFrameEnd;
                        result.message_id     = msg_id_reg;
                        result.payload_length = 10'(len_reg);
                        result.week_number    = week_reg;
                        result.ms_of_week     = ms_reg;
                        result.time_status    = tstat_reg;
                        result.received_crc   = rcv_crc;
                        result.crc_ok         = (crc_reg == rcv_crc);
                        phase_next            = bfp_pkg::PH_SYNC1;
                    end
                end
                default:
                begin
                    // Hunt for the first sync byte; stray codes land here too
                    if (rx_byte == first_sync_reg)
                    begin
                        hs0_next   = rx_byte;
                        crc_next   = crc_upd;
                        phase_next = bfp_pkg::PH_SYNC2;
                    end
                    else
                    begin
                        phase_next = bfp_pkg::PH_SYNC1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= bfp_pkg::PH_SYNC1;
            hdr_idx_reg <= '0;
            pay_idx_reg <= '0;
            len_reg     <= '0;
            trl_idx_reg <= '0;
            crc_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            pay_idx_reg <= pay_idx_next;
            len_reg     <= len_next;
            trl_idx_reg <= trl_idx_next;
            crc_reg     <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        trl_reg     <= trl_next;
        hs0_reg     <= hs0_next;
        hs1_reg     <= hs1_next;
        hs2_reg     <= hs2_next;
        msg_id_reg  <= msg_id_next;
        len_raw_reg <= len_raw_next;
        tstat_reg   <= tstat_next;
        week_reg    <= week_next;
        ms_reg      <= ms_next;
    end

endmodule

// ===== hw/rtl/bfp_queue.sv =====
// Back end: short result queue that drives the output stream.
`timescale 1ns / 1ps

module bfp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bfp_pkg::result_t  push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output bfp_pkg::result_t  out_data
);

    localparam int PW = $clog2(bfp_pkg::QueueDepth);
    localparam int CW = $clog2(bfp_pkg::QueueDepth + 1);

    bfp_pkg::result_t entry_reg [bfp_pkg::QueueDepth];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign full      = (count_reg == CW'(bfp_pkg::QueueDepth));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/binary_frame_parser_crc32.sv =====
// Top level of the binary frame parser with CRC-32 check.
//
// Input stream s_*: one received byte per transfer in s_tdata[7:0].
// Output stream m_*: m_tuser is the result kind (0 payload byte, 1 frame end);
// m_tdata carries the payload byte and its offset, or the header fields, the
// received CRC and the CRC match flag, unused fields zero.
// Config channel cfg_*: cfg_index 0..2 selects first, second, third sync byte;
// other indexes are ignored. Writes are taken every cycle.
// Throughput: one byte per cycle while s_tready is high. The framer classifies a byte
// and builds its result in the cycle it is accepted; the result is registered
// in a 4-entry queue and shown on m_* once it reaches the queue head.
// A stalled receiver lets the queue fill; s_tready drops only when the queue
// is full and rises as soon as one entry drains.
// Reset: sync bytes return to AA 44 B5, the framer hunts for the first sync
// byte and the queue empties.
`timescale 1ns / 1ps

module binary_frame_parser_crc32 #(
    parameter int MAX_PAYLOAD = 512
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,     // data_byte, byte_offset, message_id,
                                      // payload_length, week_number, ms_of_week,
                                      // time_status, received_crc, crc_ok, pad
    output logic         m_tuser,     // [0] kind
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data
);

    logic              full;
    logic              push;
    bfp_pkg::result_t  push_data;
    bfp_pkg::result_t  head;

    assign s_tready  = !full;
    assign cfg_ready = 1'b1;

    bfp_framer #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .byte_valid(s_tvalid && !full),
        .rx_byte   (s_tdata),
        .push      (push),
        .result    (push_data)
    );

    bfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (full),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (head)
    );

    assign m_tuser = head.kind;
    assign m_tdata = {4'b0000, head.crc_ok, head.received_crc, head.time_status,
                      head.ms_of_week, head.week_number, head.payload_length,
                      head.message_id, head.byte_offset, head.data_byte};

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the binary frame parser: directed frames, bytes and register writes, then random streams.
`timescale 1ns / 1ps

module tb_top;

    localparam int         MaxPayload = 512;
    localparam int         NumRows    = 23;
    localparam logic [1:0] RegUnused  = 2'd3;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_CFG,
        ROW_FRAME
    } row_op_t;

    typedef struct {
        row_op_t    op;
        logic [1:0] reg_index;    // register of a write, or of a mid-header write
        logic [7:0] value;        // raw byte, register value, or frame fill byte
        bit         rand_fill;
        logic [7:0] len_lo;
        logic [7:0] len_hi;
        int         mid_cfg_at;   // header position of a mid-frame write, -1 none
        int         want_len;     // payload_length expected, -1 when the frame is dropped
        bit         want_crc_ok;
    } stim_row_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = 8'h00;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [135:0] m_tdata;
    logic         m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = 2'd0;
    logic [7:0]   cfg_data  = 8'h00;

    // Deframer prediction state
    bfp_pkg::phase_t  ph;
    logic [7:0]       hdr [bfp_pkg::HdrLen];
    int unsigned      pos;
    int unsigned      plen;
    logic [31:0]      crc_acc;
    logic [31:0]      crc_rx;
    logic [7:0]       sync_val [3];

    bfp_pkg::result_t pending_results [$];
    int           error_count  = 0;
    int           bytes_sent   = 0;
    int           burst_left   = 0;
    int           ready_left   = 0;
    int           tx_gap_max   = 3;
    int           rx_stall_max = 4;
    bit           use_typed    = 1'b0;
    int           typed_len    = 0;
    bit           typed_crc_ok = 1'b0;

    stim_row_t directed_rows [NumRows] = '{
        '{ROW_FRAME, bfp_pkg::RegFirstSync, 8'h00, 1'b0, 8'h04, 8'h00, -1, 4, 1'b1},
        '{ROW_FRAME, bfp_pkg::RegFirstSync, 8'hFF, 1'b0, 8'h00, 8'h00, -1, 0, 1'b1},
        '{ROW_FRAME, bfp_pkg::RegFirstSync, 8'hFF, 1'b0, 8'h03, 8'h00, -1, 3, 1'b0},
        '{ROW_FRAME, bfp_pkg::RegFirstSync, 8'h00, 1'b1, 8'h00, 8'h05, -1, 5, 1'b1},
        '{ROW_FRAME, bfp_pkg::RegFirstSync, 8'h00, 1'b1, 8'hFF, 8'hFF, -1, -1, 1'b1},
        // wrong second sync byte must not restart the hunt on itself
        '{ROW_BYTE, bfp_pkg::RegFirstSync, bfp_pkg::FirstSyncReset, 1'b0, 8'h00, 8'h00,
          -1, -1, 1'b0},
        '{ROW_BYTE, bfp_pkg::RegFirstSync, bfp_pkg::FirstSyncReset, 1'b0, 8'h00, 8'h00,
          -1, -1, 1'b0},
        '{ROW_BYTE, bfp_pkg::RegFirstSync, bfp_pkg::SecondSyncReset, 1'b0, 8'h00, 8'h00,
          -1, -1, 1'b0},
        '{ROW_BYTE, bfp_pkg::RegFirstSync, bfp_pkg::ThirdSyncReset, 1'b0, 8'h00, 8'h00,
          -1, -1, 1'b0},
        '{ROW_FRAME, bfp_pkg::RegFirstSync, 8'h00, 1'b1, 8'h02, 8'h00, -1, 2, 1'b1},
        // same for a wrong third sync byte
        '{ROW_BYTE, bfp_pkg::RegFirstSync, bfp_pkg::FirstSyncReset, 1'b0, 8'h00, 8'h00,
          -1, -1, 1'b0},
        '{ROW_BYTE, bfp_pkg::RegFirstSync, bfp_pkg::SecondSyncReset, 1'b0, 8'h00, 8'h00,
          -1, -1, 1'b0},
        '{ROW_BYTE, bfp_pkg::RegFirstSync, bfp_pkg::FirstSyncReset, 1'b0, 8'h00, 8'h00,
          -1, -1, 1'b0},
        '{ROW_BYTE, bfp_pkg::RegFirstSync, bfp_pkg::SecondSyncReset, 1'b0, 8'h00, 8'h00,
          -1, -1, 1'b0},
        '{ROW_BYTE, bfp_pkg::RegFirstSync, bfp_pkg::ThirdSyncReset, 1'b0, 8'h00, 8'h00,
          -1, -1, 1'b0},
        '{ROW_CFG, bfp_pkg::RegFirstSync, 8'h00, 1'b0, 8'h00, 8'h00, -1, -1, 1'b0},
        '{ROW_CFG, bfp_pkg::RegSecondSync, 8'hFF, 1'b0, 8'h00, 8'h00, -1, -1, 1'b0},
        '{ROW_CFG, bfp_pkg::RegThirdSync, 8'h00, 1'b0, 8'h00, 8'h00, -1, -1, 1'b0},
        '{ROW_CFG, RegUnused, 8'hFF, 1'b0, 8'h00, 8'h00, -1, -1, 1'b0},
        '{ROW_FRAME, bfp_pkg::RegFirstSync, 8'h00, 1'b1, 8'h01, 8'h00, -1, 1, 1'b1},
        // third sync register changes while the header is in flight: frame dropped
        '{ROW_FRAME, bfp_pkg::RegThirdSync, 8'h00, 1'b1, 8'h02, 8'h00, 10, -1, 1'b1},
        '{ROW_FRAME, bfp_pkg::RegFirstSync, 8'h00, 1'b0, 8'h06, 8'h00, -1, 6, 1'b0},
        '{ROW_FRAME, bfp_pkg::RegFirstSync, 8'hFF, 1'b0, 8'h00, 8'h00, -1, 0, 1'b0}
    };

    binary_frame_parser_crc32 #(
        .MAX_PAYLOAD(MaxPayload)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Reflected CRC-32, one data bit at a time
    function automatic logic [31:0] crc_shift(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c;
        for (int i = 0; i < 8; i++)
        begin
            r = {1'b0, r[31:1]} ^ ((r[0] ^ d[i]) ? bfp_pkg::CrcPoly : 32'h0);
        end
        return r;
    endfunction

    task automatic deframe_byte(input logic [7:0] b, output bit emits,
                                output bfp_pkg::result_t res);
        int unsigned len_le;
        int unsigned len_sw;
        int unsigned len;
        emits = 1'b0;
        res   = '0;
        case (ph)
            bfp_pkg::PH_SYNC2:
            begin
                if (b == sync_val[1])
                begin
                    hdr[1]  = b;
                    crc_acc = crc_shift(crc_acc, b);
                    ph      = bfp_pkg::PH_SYNC3;
                end
                else
                begin
                    ph  = bfp_pkg::PH_SYNC1;
                    pos = 0;
                end
            end
            bfp_pkg::PH_SYNC3:
            begin
                if (b == sync_val[2])
                begin
                    hdr[2]  = b;
                    crc_acc = crc_shift(crc_acc, b);
                    pos     = 3;
                    ph      = bfp_pkg::PH_HEADER;
                end
                else
                begin
                    ph  = bfp_pkg::PH_SYNC1;
                    pos = 0;
                end
            end
            bfp_pkg::PH_HEADER:
            begin
                hdr[pos] = b;
                crc_acc  = crc_shift(crc_acc, b);
                pos++;
                if (pos == bfp_pkg::HdrLen)
                begin
                    len_le = 32'({hdr[7], hdr[6]});
                    len_sw = 32'({hdr[6], hdr[7]});
                    len    = len_le;
                    if (len > MaxPayload && len_sw <= MaxPayload)
                        len = len_sw;
                    if (len > MaxPayload && len >= bfp_pkg::TrailerLen &&
                        len - bfp_pkg::TrailerLen <= MaxPayload)
                        len = len - bfp_pkg::TrailerLen;
                    if (hdr[0] != sync_val[0] || hdr[1] != sync_val[1] ||
                        hdr[2] != sync_val[2] || len > MaxPayload)
                    begin
                        ph  = bfp_pkg::PH_SYNC1;
                        pos = 0;
                    end
                    else
                    begin
                        plen   = len;
                        pos    = 0;
                        crc_rx = '0;
                        ph     = (plen == 0) ? bfp_pkg::PH_TRAILER : bfp_pkg::PH_PAYLOAD;
                    end
                end
            end
            bfp_pkg::PH_PAYLOAD:
            begin
                emits           = 1'b1;
                res.kind        = bfp_pkg::KindPayload;
                res.data_byte   = b;
                res.byte_offset = 9'(pos);
                crc_acc         = crc_shift(crc_acc, b);
                pos++;
                if (pos >= plen)
                begin
                    pos    = 0;
                    crc_rx = '0;
                    ph     = bfp_pkg::PH_TRAILER;
                end
            end
            bfp_pkg::PH_TRAILER:
            begin
                crc_rx = crc_rx | (32'(b) << (8 * (pos % 4)));
                pos++;
                if (pos == bfp_pkg::TrailerLen)
                begin
                    emits              = 1'b1;
                    res.kind           = bfp_pkg::KindFrameEnd;
                    res.message_id     = {hdr[5], hdr[4]};
                    res.payload_length = 10'(plen);
                    res.week_number    = {hdr[11], hdr[10]};
                    res.ms_of_week     = {hdr[15], hdr[14], hdr[13], hdr[12]};
                    res.time_status    = hdr[9];
                    res.received_crc   = crc_rx;
                    res.crc_ok         = (crc_acc == crc_rx);
                    ph                 = bfp_pkg::PH_SYNC1;
                    pos                = 0;
                end
            end
            default:
            begin
                if (b == sync_val[0])
                begin
                    hdr[0]  = b;
                    crc_acc = crc_shift(32'h0, b);
                    ph      = bfp_pkg::PH_SYNC2;
                end
                else
                begin
                    ph = bfp_pkg::PH_SYNC1;
                end
                pos = 0;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        bit               emits;
        bfp_pkg::result_t res;
        int               gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
        deframe_byte(b, emits, res);
        if (emits)
        begin
            if (use_typed && res.kind == bfp_pkg::KindFrameEnd)
            begin
                res.payload_length = 10'(typed_len);
                res.crc_ok         = typed_crc_ok;
            end
            pending_results.push_back(res);
        end
    endtask

    // Drop tvalid, drain all results, then let the framer settle
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_sync(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            bfp_pkg::RegFirstSync:  sync_val[0] = val;
            bfp_pkg::RegSecondSync: sync_val[1] = val;
            bfp_pkg::RegThirdSync:  sync_val[2] = val;
            default:                ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Build one frame from the current sync values; payload_count < 0 takes the predicted length
    task automatic send_frame(input logic [7:0] len_lo, input logic [7:0] len_hi,
                              input logic [7:0] fill, input bit rand_fill,
                              input int payload_count, input bit crc_good,
                              input int mid_at, input logic [1:0] mid_reg);
        logic [7:0]  b;
        logic [31:0] trailer;
        int          n;
        send_byte(sync_val[0]);
        send_byte(sync_val[1]);
        send_byte(sync_val[2]);
        for (int i = 3; i < bfp_pkg::HdrLen; i++)
        begin
            if (i == mid_at)
            begin
                wait_idle();
                write_sync(mid_reg, sync_val[mid_reg] ^ 8'h01);
            end
            if (i == 6)
                b = len_lo;
            else if (i == 7)
                b = len_hi;
            else
                b = rand_fill ? 8'($urandom_range(0, 255)) : fill;
            send_byte(b);
        end
        if (ph != bfp_pkg::PH_PAYLOAD && ph != bfp_pkg::PH_TRAILER)
            return;
        n = (payload_count >= 0) ? payload_count : int'(plen);
        repeat (n) send_byte(rand_fill ? 8'($urandom_range(0, 255)) : fill);
        trailer = crc_acc;
        if (!crc_good)
            trailer = trailer ^ (32'h1 << $urandom_range(0, 31));
        for (int k = 0; k < bfp_pkg::TrailerLen; k++)
            send_byte(trailer[8 * k +: 8]);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Receiver: alternate ready runs and stall runs; no stalls when rx_stall_max is zero
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            if (m_tready && rx_stall_max != 0)
            begin
                m_tready   <= 1'b0;
                ready_left = $urandom_range(1, rx_stall_max);
            end
            else
            begin
                m_tready   <= 1'b1;
                ready_left = $urandom_range(1, 16);
            end
        end
        else
        begin
            ready_left--;
        end
    end

    always @(posedge clk)
    begin
        bfp_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: kind %0d tdata 0x%0h",
                       m_tuser, m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_tuser));
                check_field("data_byte", 32'(want.data_byte), 32'(m_tdata[7:0]));
                check_field("byte_offset", 32'(want.byte_offset), 32'(m_tdata[16:8]));
                check_field("message_id", 32'(want.message_id), 32'(m_tdata[32:17]));
                check_field("payload_length", 32'(want.payload_length),
                            32'(m_tdata[42:33]));
                check_field("week_number", 32'(want.week_number), 32'(m_tdata[58:43]));
                check_field("ms_of_week", want.ms_of_week, m_tdata[90:59]);
                check_field("time_status", 32'(want.time_status), 32'(m_tdata[98:91]));
                check_field("received_crc", want.received_crc, m_tdata[130:99]);
                check_field("crc_ok", 32'(want.crc_ok), 32'(m_tdata[131]));
            end
        end
    end

    initial
    begin
        stim_row_t  r;
        int         phase_end;
        int         pick;
        int         fill_kind;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] s0;
        logic [7:0] s1;
        logic [7:0] s2;

        ph      = bfp_pkg::PH_SYNC1;
        pos     = 0;
        plen    = 0;
        crc_acc = '0;
        crc_rx  = '0;
        foreach (hdr[i])
            hdr[i] = '0;
        sync_val[0] = bfp_pkg::FirstSyncReset;
        sync_val[1] = bfp_pkg::SecondSyncReset;
        sync_val[2] = bfp_pkg::ThirdSyncReset;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            case (r.op)
                ROW_BYTE:
                begin
                    send_byte(r.value);
                end
                ROW_CFG:
                begin
                    wait_idle();
                    write_sync(r.reg_index, r.value);
                end
                default:
                begin
                    use_typed    = 1'b1;
                    typed_len    = r.want_len;
                    typed_crc_ok = r.want_crc_ok;
                    send_frame(r.len_lo, r.len_hi, r.value, r.rand_fill, r.want_len,
                               r.want_crc_ok, r.mid_cfg_at, r.reg_index);
                    use_typed    = 1'b0;
                end
            endcase
        end

        for (int p = 0; p < 6; p++)
        begin
            s0 = 8'($urandom_range(0, 255));
            s1 = 8'($urandom_range(0, 255));
            s2 = 8'($urandom_range(0, 255));
            case (p)
                0:
                begin
                    s0 = bfp_pkg::FirstSyncReset;
                    s1 = bfp_pkg::SecondSyncReset;
                    s2 = bfp_pkg::ThirdSyncReset;
                    tx_gap_max   = 0;
                    rx_stall_max = 0;
                end
                1:
                begin
                    s0 = 8'h00;
                    s1 = 8'hFF;
                    s2 = 8'h00;
                    tx_gap_max   = 6;
                    rx_stall_max = 0;
                end
                2:
                begin
                    s0 = 8'hFF;
                    s1 = 8'hFF;
                    s2 = 8'hFF;
                    tx_gap_max   = 0;
                    rx_stall_max = 10;
                end
                3:
                begin
                    s0 = 8'h5A;
                    s1 = 8'h5A;
                    s2 = 8'h5A;
                    tx_gap_max   = 3;
                    rx_stall_max = 3;
                end
                4:
                begin
                    tx_gap_max   = 8;
                    rx_stall_max = 16;
                end
                default:
                begin
                    tx_gap_max   = 1;
                    rx_stall_max = 2;
                end
            endcase
            wait_idle();
            write_sync(bfp_pkg::RegFirstSync, s0);
            write_sync(bfp_pkg::RegSecondSync, s1);
            write_sync(bfp_pkg::RegThirdSync, s2);

            phase_end = bytes_sent + 20;
            while (bytes_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5:
                        begin
                            lo = 8'($urandom_range(0, 12));
                            hi = 8'h00;
                        end
                        6:
                        begin
                            lo = 8'h00;
                            hi = 8'($urandom_range(3, 12));
                        end
                        7, 8:
                        begin
                            lo = 8'($urandom_range(3, 255));
                            hi = 8'($urandom_range(3, 255));
                        end
                        default:
                        begin
                            lo = 8'($urandom_range(0, 255));
                            hi = 8'($urandom_range(0, 255));
                        end
                    endcase
                    fill_kind = $urandom_range(0, 9);
                    send_frame(lo, hi, (fill_kind == 0) ? 8'h00 : 8'hFF, fill_kind > 1, -1,
                               $urandom_range(0, 3) != 0, -1, bfp_pkg::RegFirstSync);
                end
                else if (pick < 80)
                begin
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
                end
                else
                begin
                    // truncated sync sequence, then random bytes
                    send_byte(sync_val[0]);
                    if ($urandom_range(0, 1) != 0)
                        send_byte(sync_val[1]);
                    repeat ($urandom_range(0, 30)) send_byte(8'($urandom_range(0, 255)));
                end
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
